/* hw/rtl/tsd_pkg.sv */
// Package for the tar stream deframer: field widths, header offsets,
// result codes, the beat structs shared between stages and the magic tables.
// No dependencies.
package tsd_pkg;

    localparam int unsigned OFF_W    = 9;
    localparam int unsigned SIZE_W   = 33;
    localparam int unsigned BLOCKS_W = 24;

    localparam logic [OFF_W-1:0] NAME_END    = 9'd100;
    localparam logic [OFF_W-1:0] SIZE_START  = 9'd124;
    localparam logic [OFF_W-1:0] SIZE_END    = 9'd136;
    localparam logic [OFF_W-1:0] TYPE_POS    = 9'd156;
    localparam logic [OFF_W-1:0] MAGIC_START = 9'd257;
    localparam logic [OFF_W-1:0] MAGIC_END   = 9'd265;
    localparam logic [OFF_W-1:0] BLOCK_LAST  = 9'd511;
    localparam logic [2:0]       MAGIC_LEN_A = 3'd6;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_REPORT   = 2'd1,
        KIND_PAYLOAD  = 2'd2,
        KIND_FINISHED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_BAD_TYPE   = 3'd2,
        ST_UNEXP_END  = 3'd3,
        ST_NORMAL_END = 3'd4
    } status_t;

    // Size field parse phase
    typedef enum logic [2:0] {
        PH_SKIP    = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_STOPPED = 3'b100
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       end_marker;
    } in_beat_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        out_byte;
        logic [SIZE_W-1:0] entry_bytes;
        status_t           status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic halted;
        logic in_data;
        logic load;
    } core_stat_t;

    function automatic logic [7:0] magic_a_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h73; // s
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h72; // r
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] magic_b_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            3'd5:    c = CHAR_SPACE;
            3'd6:    c = CHAR_SPACE;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/tsd_input_stage.sv */
// Input register of the tar stream deframer: holds one accepted beat
// until the core consumes it. Depends on tsd_pkg.
module tsd_input_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_end_marker,
    input  logic              pop,
    output tsd_pkg::in_beat_t beat
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       take;

    // Refill in the same cycle the held beat is consumed
    assign s_ready = !valid_reg || pop;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_data_byte;
            end_reg  <= s_end_marker;
        end
    end

    assign beat.valid      = valid_reg;
    assign beat.data_byte  = byte_reg;
    assign beat.end_marker = end_reg;

endmodule

/* hw/rtl/tsd_deframe_core.sv */
// Deframer core: block position, header field parsing, data region counters
// and the mode register; builds at most one result per beat. Depends on tsd_pkg.
module tsd_deframe_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  tsd_pkg::in_beat_t   beat,
    input  logic                out_free,
    output logic                pop,
    output logic                res_load,
    output tsd_pkg::result_t    res,
    output tsd_pkg::core_stat_t stat
);

    logic [tsd_pkg::OFF_W-1:0]    off_reg, off_next;
    logic                         in_data_reg, in_data_next;
    logic [tsd_pkg::BLOCKS_W-1:0] blocks_left_reg, blocks_left_next;
    logic [tsd_pkg::SIZE_W-1:0]   payload_left_reg, payload_left_next;
    logic [tsd_pkg::SIZE_W-1:0]   size_acc_reg, size_acc_next;
    tsd_pkg::phase_t              phase_reg, phase_next;
    logic                         name_ended_reg, name_ended_next;
    logic [1:0]                   magic_reg, magic_next;
    logic                         type_ok_reg, type_ok_next;
    logic                         all_zero_reg, all_zero_next;
    logic                         halted_reg, halted_next;
    logic                         extract_reg;

    logic [7:0]                 b;
    logic [2:0]                 magic_idx;
    logic [tsd_pkg::OFF_W-1:0]  magic_off;
    logic [tsd_pkg::SIZE_W-1:0] size_m1;
    logic                       emit;
    tsd_pkg::result_t           r;

    assign pop       = beat.valid && out_free;
    assign b         = beat.data_byte;
    assign magic_off = off_reg - tsd_pkg::MAGIC_START;
    assign magic_idx = magic_off[2:0];
    assign size_m1   = size_acc_reg - {{(tsd_pkg::SIZE_W-1){1'b0}}, 1'b1};

    always_comb begin
        off_next          = off_reg;
        in_data_next      = in_data_reg;
        blocks_left_next  = blocks_left_reg;
        payload_left_next = payload_left_reg;
        size_acc_next     = size_acc_reg;
        phase_next        = phase_reg;
        name_ended_next   = name_ended_reg;
        magic_next        = magic_reg;
        type_ok_next      = type_ok_reg;
        all_zero_next     = all_zero_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        r.kind            = tsd_pkg::KIND_NAME;
        r.out_byte        = 8'd0;
        r.entry_bytes     = '0;
        r.status          = tsd_pkg::ST_OK;
        r.last            = 1'b0;

        if (pop && !halted_reg) begin
            if (beat.end_marker) begin
                halted_next = 1'b1;
                emit        = 1'b1;
                r.kind      = tsd_pkg::KIND_FINISHED;
                r.status    = in_data_reg ? tsd_pkg::ST_UNEXP_END : tsd_pkg::ST_NORMAL_END;
                r.last      = 1'b1;
            end else begin
                off_next = off_reg + 9'd1;
                if (in_data_reg) begin
                    if (payload_left_reg != '0) begin
                        payload_left_next = payload_left_reg - 33'd1;
                        if (extract_reg) begin
                            emit       = 1'b1;
                            r.kind     = tsd_pkg::KIND_PAYLOAD;
                            r.out_byte = b;
                            r.last     = (payload_left_reg == 33'd1);
                        end
                    end
                    if (off_reg == tsd_pkg::BLOCK_LAST) begin
                        if (blocks_left_reg == '0) begin
                            in_data_next = 1'b0;
                        end else begin
                            blocks_left_next = blocks_left_reg - 24'd1;
                        end
                    end
                end else begin
                    if (b != tsd_pkg::CHAR_NUL) begin
                        all_zero_next = 1'b0;
                    end
                    if (off_reg < tsd_pkg::NAME_END && !name_ended_reg) begin
                        if (b == tsd_pkg::CHAR_NUL) begin
                            name_ended_next = 1'b1;
                        end else begin
                            emit       = 1'b1;
                            r.kind     = tsd_pkg::KIND_NAME;
                            r.out_byte = b;
                        end
                    end
                    if (off_reg >= tsd_pkg::SIZE_START && off_reg < tsd_pkg::SIZE_END
                        && phase_reg != tsd_pkg::PH_STOPPED) begin
                        if (phase_reg == tsd_pkg::PH_SKIP && b == tsd_pkg::CHAR_SPACE) begin
                            phase_next = phase_reg;
                        end else if (b inside {[tsd_pkg::CHAR_ZERO:tsd_pkg::CHAR_SEVEN]}) begin
                            // accum*8 + digit, saturate when any of the top three bits is set
                            if (size_acc_reg[32:30] != 3'd0) begin
                                size_acc_next = tsd_pkg::SIZE_SAT;
                            end else begin
                                size_acc_next = {size_acc_reg[29:0], b[2:0]};
                            end
                            phase_next = tsd_pkg::PH_DIGITS;
                        end else begin
                            phase_next = tsd_pkg::PH_STOPPED;
                        end
                    end
                    if (off_reg == tsd_pkg::TYPE_POS) begin
                        type_ok_next = (b == tsd_pkg::CHAR_ZERO) || (b == tsd_pkg::CHAR_NUL);
                    end
                    if (off_reg >= tsd_pkg::MAGIC_START && off_reg < tsd_pkg::MAGIC_END) begin
                        if (magic_idx < tsd_pkg::MAGIC_LEN_A
                            && b != tsd_pkg::magic_a_char(magic_idx)) begin
                            magic_next[0] = 1'b0;
                        end
                        if (b != tsd_pkg::magic_b_char(magic_idx)) begin
                            magic_next[1] = 1'b0;
                        end
                    end
                    if (off_reg == tsd_pkg::BLOCK_LAST) begin
                        emit          = 1'b1;
                        r.out_byte    = 8'd0;
                        r.entry_bytes = size_acc_reg;
                        r.kind        = tsd_pkg::KIND_REPORT;
                        if (all_zero_reg && b == tsd_pkg::CHAR_NUL) begin
                            halted_next   = 1'b1;
                            r.kind        = tsd_pkg::KIND_FINISHED;
                            r.entry_bytes = '0;
                            r.status      = tsd_pkg::ST_NORMAL_END;
                            r.last        = 1'b1;
                        end else if (magic_reg == 2'b00) begin
                            halted_next = 1'b1;
                            r.status    = tsd_pkg::ST_BAD_MAGIC;
                            r.last      = 1'b1;
                        end else if (!type_ok_reg) begin
                            halted_next = 1'b1;
                            r.status    = tsd_pkg::ST_BAD_TYPE;
                            r.last      = 1'b1;
                        end else if (size_acc_reg != '0) begin
                            in_data_next      = 1'b1;
                            payload_left_next = size_acc_reg;
                            blocks_left_next  = size_m1[32:9];
                        end
                        // clear the header trackers for the next header
                        size_acc_next   = '0;
                        phase_next      = tsd_pkg::PH_SKIP;
                        name_ended_next = 1'b0;
                        magic_next      = 2'b11;
                        type_ok_next    = 1'b0;
                        all_zero_next   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg          <= '0;
            in_data_reg      <= 1'b0;
            blocks_left_reg  <= '0;
            payload_left_reg <= '0;
            size_acc_reg     <= '0;
            phase_reg        <= tsd_pkg::PH_SKIP;
            name_ended_reg   <= 1'b0;
            magic_reg        <= 2'b11;
            type_ok_reg      <= 1'b0;
            all_zero_reg     <= 1'b1;
            halted_reg       <= 1'b0;
            extract_reg      <= 1'b0;
        end else begin
            off_reg          <= off_next;
            in_data_reg      <= in_data_next;
            blocks_left_reg  <= blocks_left_next;
            payload_left_reg <= payload_left_next;
            size_acc_reg     <= size_acc_next;
            phase_reg        <= phase_next;
            name_ended_reg   <= name_ended_next;
            magic_reg        <= magic_next;
            type_ok_reg      <= type_ok_next;
            all_zero_reg     <= all_zero_next;
            halted_reg       <= halted_next;
            if (cfg_wr_en) begin
                extract_reg <= cfg_wr_data;
            end
        end
    end

    assign res_load     = emit;
    assign res          = r;
    assign stat.halted  = halted_reg;
    assign stat.in_data = in_data_reg;
    assign stat.load    = emit;

endmodule

/* hw/rtl/tsd_output_stage.sv */
// Result register of the tar stream deframer: holds one result beat until
// the sink takes it. Depends on tsd_pkg.
module tsd_output_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  tsd_pkg::result_t         res,
    output logic                     out_free,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_kind,
    output logic [7:0]               m_out_byte,
    output logic [tsd_pkg::SIZE_W-1:0] m_entry_bytes,
    output logic [2:0]               m_status,
    output logic                     m_last
);

    logic             valid_reg, valid_next;
    tsd_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = res_reg.kind;
    assign m_out_byte    = res_reg.out_byte;
    assign m_entry_bytes = res_reg.entry_bytes;
    assign m_status      = res_reg.status;
    assign m_last        = res_reg.last;

endmodule

/* hw/rtl/tar_stream_deframer.sv */
// Top level of the tar stream deframer: input register, deframer core and
// result register. Depends on tsd_pkg, tsd_input_stage, tsd_deframe_core,
// tsd_output_stage.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | data_byte[7:0], end_marker
//  m_      | out       | m_valid / m_ready  | kind[1:0], out_byte[7:0], entry_bytes[32:0],
//          |           |                    | status[2:0], last
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data (extract mode)
//
// One beat per cycle sustained while m_ready stays high. A beat's result, if it
// makes one, shows on m_valid after the beat has passed through the input
// register: the core works on the input register and loads the result register.
// Reset (aresetn, synchronous) clears all control state and the mode bit.
// While the result register waits on m_ready, one more beat is held in the
// input register; s_ready drops only when both are full.
module tar_stream_deframer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_end_marker,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [7:0]                 m_out_byte,
    output logic [tsd_pkg::SIZE_W-1:0] m_entry_bytes,
    output logic [2:0]                 m_status,
    output logic                       m_last
);

    tsd_pkg::in_beat_t   beat;
    tsd_pkg::result_t    res;
    tsd_pkg::core_stat_t stat;
    logic                pop;
    logic                out_free;
    logic                res_load;

    tsd_input_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_end_marker (s_end_marker),
        .pop          (pop),
        .beat         (beat)
    );

    tsd_deframe_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat        (beat),
        .out_free    (out_free),
        .pop         (pop),
        .res_load    (res_load),
        .res         (res),
        .stat        (stat)
    );

    tsd_output_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_entry_bytes (m_entry_bytes),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    // A halted block loads no further result
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.halted |-> !stat.load)
        else $error("result loaded after halt");

    // A result is only loaded when the result register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load |-> out_free && beat.valid)
        else $error("result loaded into busy output");

    // A finished result always ends the stream
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == tsd_pkg::KIND_FINISHED |-> m_last)
        else $error("finished result without last");

    // Payload beats only come from the data region
    a_payload_region: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load && res.kind == tsd_pkg::KIND_PAYLOAD |-> stat.in_data)
        else $error("payload beat outside data region");

endmodule
